/* design/ps2_mux_link_framer_assert.svh */
// Assertion macros shared by the link framer modules.
`ifndef PS2_MUX_LINK_FRAMER_ASSERT_SVH
`define PS2_MUX_LINK_FRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define PS2MF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("ps2 mux framer: assertion failed");
`define PS2MF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ps2 mux framer: assertion failed");
`else
`define PS2MF_ASSERT(lbl, prop)
`define PS2MF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/ps2mf_pkg.sv */
// Types, codes and helpers of the PS/2 multiplexer link framer.
`timescale 1ns / 1ps
package ps2mf_pkg;

    typedef enum logic [1:0] {
        KIND_RX    = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2,
        KIND_START = 2'd3
    } kind_t;

    localparam logic [7:0] SEL_KEYBOARD = 8'hA0;
    localparam logic [7:0] SEL_MOUSE    = 8'hA1;
    localparam logic [7:0] CODE_ESCAPE  = 8'h7D;
    localparam logic [7:0] CODE_BSYNC   = 8'h7E;
    localparam logic [7:0] CODE_START   = 8'h55;
    localparam logic [7:0] CODE_END     = 8'h56;

    localparam logic PORT_KEYBOARD = 1'b0;
    localparam logic PORT_MOUSE    = 1'b1;

    localparam logic OUT_LINE = 1'b0;
    localparam logic OUT_READ = 1'b1;

    // One accepted item that still owes results
    typedef struct packed {
        kind_t      kind;
        logic       sel;    // selector byte still to send
        logic       esc;    // escape byte still to send
        logic       ok;     // read found a byte
        logic [7:0] data;
    } job_t;

    function automatic logic is_control(input logic [7:0] b);
        is_control = (b == SEL_KEYBOARD) || (b == SEL_MOUSE) || (b == CODE_ESCAPE) ||
                     (b == CODE_BSYNC) || (b == CODE_START) || (b == CODE_END);
    endfunction

endpackage

/* design/ps2_mux_link_framer.sv */
// Top level of the PS/2 multiplexer link framer.
`timescale 1ns / 1ps
`include "ps2_mux_link_framer_assert.svh"
// Input channel s_*: one item per handshake; s_tuser holds the kind (received line
// byte, host keyboard write, host keyboard read, session start), s_tdata the byte.
// Received bytes are deframed into the keyboard queue and give no result. A write
// gives one or two line bytes (an escape ahead of control codes), a read gives one
// response popped from the queue, a start gives the 0x55 line byte.
// Output channel m_*: m_tdata is the byte, m_tuser the result kind and read flag,
// m_tlast marks the final result of an item.
// An accepted item waits in the sequencer register, which writes its first result
// to the output register. Throughput: one item per cycle while m_tready is high; a
// write that needs an escape holds the single result sequencer for both line bytes.
// The queue is a RAM with one write and one registered read port; the read is issued
// when the read item is accepted, so the data is ready when its result is formed.
// Reset: synchronous and active low; empties the queue, clears the escape state
// and selects the keyboard for both ports. No clearing pass is run.
// When m_tready is low, one result waits in the output register and one more item
// is held in the sequencer; s_tready then drops until the sequencer frees.
module ps2_mux_link_framer #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [1:0] s_tuser,   // [1:0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] out_kind, [1] read_ok
    output logic       m_tlast
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic             esc_reg, esc_next;
    logic             rx_port_reg, rx_port_next;
    logic             tx_port_reg, tx_port_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;

    ps2mf_pkg::kind_t in_kind;
    ps2mf_pkg::job_t  job;
    logic             s_fire;
    logic             can_load;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    logic [7:0]       rd_data;

    assign in_kind  = ps2mf_pkg::kind_t'(s_tuser);
    assign s_tready = can_load;
    assign s_fire   = s_tvalid && s_tready;
    assign q_empty  = (head_reg == tail_reg);
    assign q_full   = (ptr_next(tail_reg) == head_reg);

    always_comb begin
        esc_next     = esc_reg;
        rx_port_next = rx_port_reg;
        tx_port_next = tx_port_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        push         = 1'b0;
        pop          = 1'b0;
        job.kind     = in_kind;
        job.sel      = (tx_port_reg != ps2mf_pkg::PORT_KEYBOARD);
        job.esc      = ps2mf_pkg::is_control(s_tdata);
        job.ok       = !q_empty;
        job.data     = s_tdata;
        if (s_fire) begin
            unique case (in_kind)
                ps2mf_pkg::KIND_RX: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        push     = (rx_port_reg == ps2mf_pkg::PORT_KEYBOARD);
                    end else begin
                        case (s_tdata) inside
                            ps2mf_pkg::CODE_ESCAPE:  esc_next = 1'b1;
                            ps2mf_pkg::CODE_BSYNC:   rx_port_next = tx_port_reg;
                            ps2mf_pkg::SEL_KEYBOARD: rx_port_next = ps2mf_pkg::PORT_KEYBOARD;
                            ps2mf_pkg::SEL_MOUSE:    rx_port_next = ps2mf_pkg::PORT_MOUSE;
                            ps2mf_pkg::CODE_START, ps2mf_pkg::CODE_END: begin
                            end
                            default: push = (rx_port_reg == ps2mf_pkg::PORT_KEYBOARD);
                        endcase
                    end
                end
                ps2mf_pkg::KIND_WRITE: begin
                    tx_port_next = ps2mf_pkg::PORT_KEYBOARD;
                end
                ps2mf_pkg::KIND_READ: begin
                    pop = !q_empty;
                end
                ps2mf_pkg::KIND_START: begin
                    tx_port_next = ps2mf_pkg::PORT_KEYBOARD;
                    rx_port_next = ps2mf_pkg::PORT_KEYBOARD;
                end
                default: begin
                end
            endcase
        end
        // full queue: drop the oldest byte before storing
        if (push) begin
            tail_next = ptr_next(tail_reg);
            if (q_full) begin
                head_next = ptr_next(head_reg);
            end
        end
        if (pop) begin
            head_next = ptr_next(head_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg     <= 1'b0;
            rx_port_reg <= ps2mf_pkg::PORT_KEYBOARD;
            tx_port_reg <= ps2mf_pkg::PORT_KEYBOARD;
            head_reg    <= '0;
            tail_reg    <= '0;
        end else begin
            esc_reg     <= esc_next;
            rx_port_reg <= rx_port_next;
            tx_port_reg <= tx_port_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
    end

    ps2mf_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .we      (push),
        .wr_addr (tail_reg),
        .wr_data (s_tdata),
        .re      (pop),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    ps2mf_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_fire && (in_kind != ps2mf_pkg::KIND_RX)),
        .job_in   (job),
        .rd_data  (rd_data),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `PS2MF_ASSERT_NEXT(a_push_not_empty, push, head_reg != tail_reg)
    `PS2MF_ASSERT_NEXT(a_start_ports, s_fire && (in_kind == ps2mf_pkg::KIND_START),
                       !rx_port_reg && !tx_port_reg)
    `PS2MF_ASSERT(a_no_push_pop, !(push && pop))
    `PS2MF_ASSERT(a_tx_keyboard, tx_port_reg == ps2mf_pkg::PORT_KEYBOARD)

endmodule

/* design/ps2mf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ps2mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (re) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* design/ps2mf_emit.sv */
// Result sequencer: holds one pending item and feeds the output register.
`timescale 1ns / 1ps
`include "ps2_mux_link_framer_assert.svh"
module ps2mf_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  ps2mf_pkg::job_t  job_in,
    input  logic [7:0]       rd_data,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [1:0]       m_tuser,   // [0] out_kind, [1] read_ok
    output logic             m_tlast
);

    ps2mf_pkg::job_t job_reg;
    logic            job_valid_reg;
    logic            m_tvalid_reg;
    logic [7:0]      m_tdata_reg;
    logic [1:0]      m_tuser_reg;
    logic            m_tlast_reg;

    logic       out_free;
    logic       emit;
    logic [7:0] e_byte;
    logic       e_kind;
    logic       e_ok;
    logic       e_last;

    always_comb begin
        e_byte = 8'h00;
        e_kind = ps2mf_pkg::OUT_LINE;
        e_ok   = 1'b0;
        e_last = 1'b1;
        unique case (job_reg.kind)
            ps2mf_pkg::KIND_WRITE: begin
                if (job_reg.sel) begin
                    e_byte = ps2mf_pkg::SEL_KEYBOARD;
                    e_last = 1'b0;
                end else if (job_reg.esc) begin
                    e_byte = ps2mf_pkg::CODE_ESCAPE;
                    e_last = 1'b0;
                end else begin
                    e_byte = job_reg.data;
                end
            end
            ps2mf_pkg::KIND_READ: begin
                e_kind = ps2mf_pkg::OUT_READ;
                e_ok   = job_reg.ok;
                e_byte = job_reg.ok ? rd_data : 8'h00;
            end
            ps2mf_pkg::KIND_START: begin
                e_byte = ps2mf_pkg::CODE_START;
            end
            default: begin
                e_byte = 8'h00;
            end
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = job_valid_reg && out_free;
    assign can_load = !job_valid_reg || (out_free && e_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (load) begin
            job_valid_reg <= 1'b1;
        end else if (emit && e_last) begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= job_in;
        end else if (emit) begin
            // drop the prefix byte just sent
            if (job_reg.sel) begin
                job_reg.sel <= 1'b0;
            end else begin
                job_reg.esc <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= e_byte;
            m_tuser_reg <= {e_ok, e_kind};
            m_tlast_reg <= e_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `PS2MF_ASSERT(a_prefix_is_line_byte, !(m_tvalid_reg && !m_tlast_reg) || (m_tuser_reg == 2'b00))
    `PS2MF_ASSERT_NEXT(a_read_single, emit && (job_reg.kind == ps2mf_pkg::KIND_READ),
                       m_tvalid_reg && m_tuser_reg[0] && m_tlast_reg)
    `PS2MF_ASSERT_NEXT(a_no_load_over_job, load && job_valid_reg && !(emit && e_last), 1'b0)

endmodule

/* sim/ps2_mux_link_framer_tb.sv */
// Self-checking testbench of the PS/2 multiplexer link framer, keyboard side.
`timescale 1ns / 1ps
module ps2_mux_link_framer_tb;

    localparam int KEY_DEPTH      = 32;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] out_byte;
        logic       read_ok;
        logic       last;
    } link_result_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] in_byte
    logic [1:0] s_tuser;    // [1:0] kind
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic [1:0] m_tuser;    // [0] out_kind, [1] read_ok
    logic       m_tlast;

    // Mirror of the block state
    logic       rx_escaped;
    logic       rx_port;
    logic       tx_port;
    logic [7:0] key_ring [KEY_DEPTH];
    int         key_head;
    int         key_tail;

    link_result_t owed_link_bytes [$];
    link_result_t want;

    logic no_idle;
    int   fail_count;
    int   stalled_cycles;
    int   results_checked;
    int   key_drops;
    int   key_peak;
    int   items_of_kind [4];

    ps2_mux_link_framer #(
        .QUEUE_DEPTH(KEY_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic owe(input logic okind, input logic [7:0] obyte, input logic ok,
                       input logic lst);
        owed_link_bytes.push_back('{okind, obyte, ok, lst});
    endtask

    task automatic push_key(input logic [7:0] b);
        int fill;
        // drop the oldest byte when full
        if ((key_tail + 1) % KEY_DEPTH == key_head) begin
            key_head = (key_head + 1) % KEY_DEPTH;
            key_drops++;
        end
        key_ring[key_tail] = b;
        key_tail = (key_tail + 1) % KEY_DEPTH;
        fill = (key_tail - key_head + KEY_DEPTH) % KEY_DEPTH;
        if (fill > key_peak) key_peak = fill;
    endtask

    // Deframe line bytes, frame host writes and starts, serve reads from the keyboard ring
    task automatic frame_host_item(input ps2mf_pkg::kind_t k, input logic [7:0] b);
        items_of_kind[k]++;
        case (k)
            ps2mf_pkg::KIND_RX: begin
                if (rx_escaped) begin
                    rx_escaped = 1'b0;
                    if (rx_port == ps2mf_pkg::PORT_KEYBOARD) push_key(b);
                end else begin
                    case (b)
                        ps2mf_pkg::CODE_ESCAPE:  rx_escaped = 1'b1;
                        ps2mf_pkg::CODE_BSYNC:   rx_port = tx_port;
                        ps2mf_pkg::SEL_KEYBOARD: rx_port = ps2mf_pkg::PORT_KEYBOARD;
                        ps2mf_pkg::SEL_MOUSE:    rx_port = ps2mf_pkg::PORT_MOUSE;
                        ps2mf_pkg::CODE_START, ps2mf_pkg::CODE_END: ;
                        default: begin
                            if (rx_port == ps2mf_pkg::PORT_KEYBOARD) push_key(b);
                        end
                    endcase
                end
            end
            ps2mf_pkg::KIND_WRITE: begin
                if (tx_port != ps2mf_pkg::PORT_KEYBOARD) begin
                    owe(ps2mf_pkg::OUT_LINE, ps2mf_pkg::SEL_KEYBOARD, 1'b0, 1'b0);
                    tx_port = ps2mf_pkg::PORT_KEYBOARD;
                end
                if (b inside {ps2mf_pkg::SEL_KEYBOARD, ps2mf_pkg::SEL_MOUSE,
                              ps2mf_pkg::CODE_ESCAPE, ps2mf_pkg::CODE_BSYNC,
                              ps2mf_pkg::CODE_START, ps2mf_pkg::CODE_END})
                    owe(ps2mf_pkg::OUT_LINE, ps2mf_pkg::CODE_ESCAPE, 1'b0, 1'b0);
                owe(ps2mf_pkg::OUT_LINE, b, 1'b0, 1'b1);
            end
            ps2mf_pkg::KIND_READ: begin
                if (key_head == key_tail) begin
                    owe(ps2mf_pkg::OUT_READ, 8'h00, 1'b0, 1'b1);
                end else begin
                    owe(ps2mf_pkg::OUT_READ, key_ring[key_head], 1'b1, 1'b1);
                    key_head = (key_head + 1) % KEY_DEPTH;
                end
            end
            default: begin
                // escape state survives a session start
                tx_port = ps2mf_pkg::PORT_KEYBOARD;
                rx_port = ps2mf_pkg::PORT_KEYBOARD;
                owe(ps2mf_pkg::OUT_LINE, ps2mf_pkg::CODE_START, 1'b0, 1'b1);
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input ps2mf_pkg::kind_t k, input logic [7:0] b);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = k;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        frame_host_item(k, b);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        // lean towards the link codes
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       return ps2mf_pkg::SEL_KEYBOARD;
            1:       return ps2mf_pkg::SEL_MOUSE;
            2:       return ps2mf_pkg::CODE_ESCAPE;
            3:       return ps2mf_pkg::CODE_BSYNC;
            4:       return ps2mf_pkg::CODE_START;
            default: return ps2mf_pkg::CODE_END;
        endcase
    endfunction

    task automatic test_directed();
        send_item(ps2mf_pkg::KIND_READ, 8'hFF);     // empty queue
        send_item(ps2mf_pkg::KIND_RX, 8'h00);
        send_item(ps2mf_pkg::KIND_RX, 8'hFF);
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::CODE_ESCAPE);
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::CODE_BSYNC);  // escaped control code is data
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::CODE_START);
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::CODE_END);
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::SEL_MOUSE);
        send_item(ps2mf_pkg::KIND_RX, 8'h33);       // mouse data, discarded
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::CODE_ESCAPE);
        // escaped on the mouse port, discarded
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::SEL_KEYBOARD);
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::CODE_BSYNC);  // back to the transmit port
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::CODE_ESCAPE);
        send_item(ps2mf_pkg::KIND_START, 8'hA5);
        send_item(ps2mf_pkg::KIND_RX, ps2mf_pkg::SEL_KEYBOARD);
        send_item(ps2mf_pkg::KIND_WRITE, 8'h00);
        send_item(ps2mf_pkg::KIND_WRITE, 8'hFF);
        send_item(ps2mf_pkg::KIND_WRITE, ps2mf_pkg::CODE_ESCAPE);
        send_item(ps2mf_pkg::KIND_WRITE, ps2mf_pkg::SEL_MOUSE);
        send_item(ps2mf_pkg::KIND_WRITE, ps2mf_pkg::CODE_START);
        repeat (5) send_item(ps2mf_pkg::KIND_READ, 8'h00);
    endtask

    task automatic test_queue_overflow();
        send_item(ps2mf_pkg::KIND_START, 8'h00);
        repeat (40) send_item(ps2mf_pkg::KIND_RX, 8'($urandom_range(0, 8'h54)));
        repeat (33) send_item(ps2mf_pkg::KIND_READ, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random(input int count, input int read_pct);
        int               r;
        ps2mf_pkg::kind_t k;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < read_pct)            k = ps2mf_pkg::KIND_READ;
            else if (r < read_pct + 18)  k = ps2mf_pkg::KIND_WRITE;
            else if (r < read_pct + 21)  k = ps2mf_pkg::KIND_START;
            else                         k = ps2mf_pkg::KIND_RX;
            send_item(k, pick_byte());
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random(70, 30);
    endtask

    initial begin : downstream_stall
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!no_idle && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_link_bytes.size() == 0) begin
                fail_count++;
                $display("%0t: expected no result, actual byte %h user %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
            end else begin
                want = owed_link_bytes.pop_front();
                results_checked++;
                if (m_tuser[0] !== want.out_kind) begin
                    fail_count++;
                    $display("%0t: out_kind expected %b actual %b",
                             $time, want.out_kind, m_tuser[0]);
                end
                if (m_tdata !== want.out_byte) begin
                    fail_count++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, m_tdata);
                end
                if (m_tuser[1] !== want.read_ok) begin
                    fail_count++;
                    $display("%0t: read_ok expected %b actual %b",
                             $time, want.read_ok, m_tuser[1]);
                end
                if (m_tlast !== want.last) begin
                    fail_count++;
                    $display("%0t: last expected %b actual %b", $time, want.last, m_tlast);
                end
            end
        end
    end

    initial begin : watchdog
        stalled_cycles = 0;
        while (stalled_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, owed_link_bytes.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = ps2mf_pkg::KIND_RX;
        no_idle    = 1'b0;
        rx_escaped = 1'b0;
        rx_port    = ps2mf_pkg::PORT_KEYBOARD;
        tx_port    = ps2mf_pkg::PORT_KEYBOARD;
        key_head   = 0;
        key_tail   = 0;
        fail_count = 0;
        results_checked = 0;
        key_drops  = 0;
        key_peak   = 0;
        foreach (items_of_kind[i]) items_of_kind[i] = 0;
        foreach (key_ring[i]) key_ring[i] = 8'h00;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_queue_overflow();
        test_random(130, 15);
        test_random(130, 45);
        test_back_to_back();

        s_tvalid = 1'b0;
        while (owed_link_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("items: %0d line bytes, %0d writes, %0d reads, %0d session starts",
                 items_of_kind[ps2mf_pkg::KIND_RX], items_of_kind[ps2mf_pkg::KIND_WRITE],
                 items_of_kind[ps2mf_pkg::KIND_READ], items_of_kind[ps2mf_pkg::KIND_START]);
        $display("results checked: %0d, queue peak %0d, oldest bytes dropped %0d",
                 results_checked, key_peak, key_drops);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
